### rtl/core/grce_pkg.sv
// Shared types, codes and pixel helpers for the glyph row color expander.
`timescale 1ns / 1ps
`default_nettype none

package grce_pkg;

	localparam int GLYPH_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_OPAQUE      = 2'd0,
		OP_MASKED      = 2'd1,
		OP_TRANSPARENT = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		FMT_ARGB1555 = 2'd0,
		FMT_RGB565   = 2'd1,
		FMT_BGR24    = 2'd2,
		FMT_XRGB32   = 2'd3
	} fmt_e;

	localparam logic [1:0] CFG_FRAME_BASE   = 2'd0;
	localparam logic [1:0] CFG_LINE_STRIDE  = 2'd1;
	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] row_y;
		logic [15:0] col_x;
		logic [15:0] glyph_bits;
		logic [15:0] mask_bits;
		logic [24:0] fore_colour_0;
		logic [24:0] fore_colour_1;
		logic [24:0] back_colour_0;
		logic [24:0] back_colour_1;
	} in_item_t;

	typedef struct packed {
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic [2:0]  write_bytes;
		logic        last_write;
	} out_item_t;

	// Item after the front end: line offset and colors already in target format
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] col_x;
		logic [15:0] glyph_bits;
		logic [15:0] mask_bits;
		logic [31:0] line_off;
		logic [23:0] fore_0;
		logic [23:0] fore_1;
		logic [23:0] back_0;
		logic [23:0] back_1;
	} front_t;

	// One pixel slot of the chain
	typedef struct packed {
		logic valid;
		logic fg;
		logic sel;
		logic last;
	} cell_t;

	function automatic logic [2:0] pix_bytes(fmt_e fmt);
		logic [2:0] n;
		case (fmt)
			FMT_ARGB1555, FMT_RGB565: n = 3'd2;
			FMT_BGR24:                n = 3'd3;
			default:                  n = 3'd4;
		endcase
		return n;
	endfunction

	// x times the pixel size in bytes
	function automatic logic [17:0] nb_scale(logic [15:0] x, fmt_e fmt);
		logic [17:0] r;
		case (fmt)
			FMT_ARGB1555, FMT_RGB565: r = {1'b0, x, 1'b0};
			FMT_BGR24:                r = {1'b0, x, 1'b0} + {2'b00, x};
			default:                  r = {x, 2'b00};
		endcase
		return r;
	endfunction

	function automatic logic [23:0] conv_colour(logic [24:0] c, fmt_e fmt);
		logic [23:0] r;
		case (fmt)
			FMT_ARGB1555: r = {8'd0, c[24], c[23:19], c[15:11], c[7:3]};
			FMT_RGB565:   r = {8'd0, c[23:19], c[15:10], c[7:3]};
			default:      r = c[23:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/glyph_row_color_expander_unit.sv
// Top level of the glyph row color expander: config registers, cell chain, write output.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted glyph row becomes up to GLYPH_WIDTH framebuffer pixel writes, one
// beat per cycle while out_ready is high, issued from the rightmost pixel (glyph
// bit 0) to the leftmost, with last_write set on the row's final write; rows that
// paint nothing give no beat. A row passes an input register and a multiply/convert
// stage, then is loaded in parallel into a chain of GLYPH_WIDTH pixel cells that
// shifts one cell per cycle into the output register unless the output stalls. A
// row holds the chain until its highest painted glyph bit moves out, and the next
// row loads in the cycle its last cell moves out. Configuration takes one write
// per cycle and must only change while idle.

module glyph_row_color_expander_unit
	import grce_pkg::*;
#(
	parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item
);

	localparam int OW = $clog2(GLYPH_WIDTH);

	logic [31:0] frame_base_q;
	logic [15:0] line_stride_q;
	fmt_e        fmt_q;

	logic   s2_valid;
	logic   s2_ready;
	front_t s2_data;

	cell_t cell_q  [GLYPH_WIDTH+1];
	cell_t cell_ld [GLYPH_WIDTH];

	logic [GLYPH_WIDTH-1:0] bits_w;
	logic [GLYPH_WIDTH-1:0] mask_w;
	logic [GLYPH_WIDTH-1:0] emit_w;
	logic [GLYPH_WIDTH-1:0] sel_w;
	logic [GLYPH_WIDTH-1:0] last_w;
	logic [GLYPH_WIDTH-1:0] last_vec;
	logic                   busy_tail;
	logic                   shift_en;
	logic                   load_en;

	logic [OW-1:0] off_q;
	logic [31:0]   base_q;
	logic [23:0]   fore0_q;
	logic [23:0]   fore1_q;
	logic [23:0]   back0_q;
	logic [23:0]   back1_q;

	logic [31:0] head_addr;
	logic [23:0] head_data;
	out_item_t   out_q;
	logic        out_valid_q;

	// Config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= '0;
			line_stride_q <= '0;
			fmt_q         <= FMT_XRGB32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_BASE:   frame_base_q  <= cfg_data;
				CFG_LINE_STRIDE:  line_stride_q <= cfg_data[15:0];
				CFG_PIXEL_FORMAT: fmt_q         <= fmt_e'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	grce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.fmt         (fmt_q),
		.line_stride (line_stride_q),
		.s2_valid    (s2_valid),
		.s2_ready    (s2_ready),
		.s2_data     (s2_data)
	);

	// Per-pixel load values; last marks the highest painted bit
	always_comb begin
		bits_w = GLYPH_WIDTH'(s2_data.glyph_bits);
		mask_w = GLYPH_WIDTH'(s2_data.mask_bits);
		sel_w  = '0;
		case (op_e'(s2_data.opcode))
			OP_OPAQUE:      emit_w = '1;
			OP_MASKED: begin
				emit_w = '1;
				sel_w  = mask_w;
			end
			OP_TRANSPARENT: emit_w = bits_w;
			default:        emit_w = '0;
		endcase
		for (int i = 0; i < GLYPH_WIDTH; i++) begin
			last_w[i]        = emit_w[i] & ~|(emit_w >> (i + 1));
			cell_ld[i].valid = emit_w[i];
			cell_ld[i].fg    = bits_w[i];
			cell_ld[i].sel   = sel_w[i];
			cell_ld[i].last  = last_w[i];
		end
	end

	always_comb begin
		busy_tail = 1'b0;
		for (int i = 1; i < GLYPH_WIDTH; i++) begin
			busy_tail = busy_tail | cell_q[i].valid;
		end
		for (int i = 0; i < GLYPH_WIDTH; i++) begin
			last_vec[i] = cell_q[i].valid & cell_q[i].last;
		end
	end

	assign shift_en = !cell_q[0].valid || !out_valid_q || out_ready;
	assign load_en  = s2_valid && !busy_tail && shift_en;
	assign s2_ready = load_en;

	assign cell_q[GLYPH_WIDTH] = '0;

	for (genvar g = 0; g < GLYPH_WIDTH; g++) begin : g_cell
		grce_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift_en),
			.load     (load_en),
			.load_val (cell_ld[g]),
			.next_val (cell_q[g+1]),
			.value    (cell_q[g])
		);
	end

	// Row context shared by the cells of the row in the chain
	always_ff @(posedge clk) begin
		if (load_en) begin
			base_q  <= frame_base_q + s2_data.line_off + 32'(nb_scale(s2_data.col_x, fmt_q));
			fore0_q <= s2_data.fore_0;
			fore1_q <= s2_data.fore_1;
			back0_q <= s2_data.back_0;
			back1_q <= s2_data.back_1;
		end
	end

	// Pixel offset of the head cell within the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (load_en) begin
			off_q <= OW'(GLYPH_WIDTH - 1);
		end else if (shift_en) begin
			off_q <= off_q - 1'b1;
		end
	end

	always_comb begin
		head_addr = base_q + 32'(nb_scale(16'(off_q), fmt_q));
		case ({cell_q[0].fg, cell_q[0].sel})
			2'b11:   head_data = fore1_q;
			2'b10:   head_data = fore0_q;
			2'b01:   head_data = back1_q;
			default: head_data = back0_q;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift_en && cell_q[0].valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en && cell_q[0].valid) begin
			out_q.write_address <= head_addr;
			out_q.write_data    <= 32'(head_data);
			out_q.write_bytes   <= pix_bytes(fmt_q);
			out_q.last_write    <= cell_q[0].last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	// The chain never holds more than one row end
	a_one_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(last_vec) <= 1)
		else $error("chain holds more than one last cell");

	// A row end at the head has nothing painted behind it
	a_end_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_q[0].valid && cell_q[0].last) |-> !busy_tail)
		else $error("valid cells behind the last cell of a row");

	// A load restarts the pixel offset at the rightmost pixel
	a_off_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |=> (off_q == OW'(GLYPH_WIDTH - 1)))
		else $error("pixel offset not restarted on load");
`endif

endmodule

`default_nettype wire

### rtl/core/grce_cell.sv
// One pixel slot of the expansion chain: parallel load, shift toward the head.
`timescale 1ns / 1ps
`default_nettype none

module grce_cell
	import grce_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift,
	input  wire logic  load,
	input  wire cell_t load_val,
	input  wire cell_t next_val,
	output cell_t      value
);

	cell_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load) begin
			state_q <= load_val;
		end else if (shift) begin
			state_q <= next_val;
		end
	end

	assign value = state_q;

endmodule

`default_nettype wire

### rtl/core/grce_front.sv
// Front end: input register, line offset multiply and color conversion.
`timescale 1ns / 1ps
`default_nettype none

module grce_front
	import grce_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire in_item_t in_item,
	input  wire fmt_e  fmt,
	input  wire logic [15:0] line_stride,
	output logic       s2_valid,
	input  wire logic  s2_ready,
	output front_t     s2_data
);

	in_item_t s1_q;
	logic     valid_s1;
	logic     valid_s2;
	front_t   data_s2;
	front_t   nx_s2;
	logic     move_s1;

	assign move_s1  = valid_s1 && (!valid_s2 || s2_ready);
	assign in_ready = !valid_s1 || move_s1;

	always_comb begin
		nx_s2.opcode     = s1_q.opcode;
		nx_s2.col_x      = s1_q.col_x;
		nx_s2.glyph_bits = s1_q.glyph_bits;
		nx_s2.mask_bits  = s1_q.mask_bits;
		nx_s2.line_off   = 32'(line_stride) * 32'(s1_q.row_y);
		nx_s2.fore_0     = conv_colour(s1_q.fore_colour_0, fmt);
		nx_s2.fore_1     = conv_colour(s1_q.fore_colour_1, fmt);
		nx_s2.back_0     = conv_colour(s1_q.back_colour_0, fmt);
		nx_s2.back_1     = conv_colour(s1_q.back_colour_1, fmt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_q <= in_item;
		end
		if (move_s1) begin
			data_s2 <= nx_s2;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

`default_nettype wire
